// File: src/gbst_pkg.sv
package gbst_pkg;

    localparam int DIM    = 64;
    localparam int POS_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int RANK_W = $clog2(DIM + 1);
    localparam int RES_RANK_W = 7;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [DIM-1:0] vec;
        logic           done;
        logic           stored;
    } t_item;

endpackage

// File: src/gbst_cell.sv
module gbst_cell
    import gbst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [POS_W-1:0] i_pos,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_valid,
    output t_item            o_item
);

    logic           r_occ;
    logic           n_occ;
    logic [DIM-1:0] r_row;
    logic [DIM-1:0] n_row;
    logic           r_valid;
    t_item          r_item;
    t_item          n_item;
    logic           w_bit;

    assign w_bit = i_item.vec[i_pos];

    always_comb begin
        n_item = i_item;
        n_occ  = r_occ;
        n_row  = r_row;
        if (i_valid) begin
            case (i_item.cmd)
                CMD_CLEAR: begin
                    n_occ = 1'b0;
                end
                CMD_INSERT, CMD_QUERY: begin
                    if (!i_item.done && w_bit) begin
                        if (r_occ) begin
                            n_item.vec = i_item.vec ^ r_row;
                        end else begin
                            n_item.done = 1'b1;
                            if (i_item.cmd == CMD_INSERT) begin
                                n_occ         = 1'b1;
                                n_row         = i_item.vec;
                                n_item.stored = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_occ   <= n_occ;
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= n_row;
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: src/gbst_out.sv
module gbst_out
    import gbst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_tvalid,
    output logic [7:0] o_tdata
);

    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] n_rank;
    logic              r_valid;
    logic              r_span;
    logic              n_span;

    always_comb begin
        n_rank = r_rank;
        n_span = 1'b0;
        case (i_item.cmd)
            CMD_CLEAR: begin
                n_rank = '0;
            end
            CMD_INSERT: begin
                if (i_item.stored) begin
                    n_rank = r_rank + RANK_W'(1);
                end
                n_span = !i_item.done;
            end
            CMD_QUERY: begin
                n_span = !i_item.done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_rank <= n_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_span <= n_span;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {RES_RANK_W'(r_rank), r_span};

    a_rank_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (o_tdata[7:1] <= 7'(DIM)))
        else $error("rank above dimension");

    a_clear_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_item.cmd == CMD_CLEAR) |=> (o_tdata == 8'd0))
        else $error("clear result not zero");

    a_rank_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && i_valid) |=> $stable(r_rank))
        else $error("rank moved without a request");

    a_store_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_item.stored) |=> !o_tdata[0])
        else $error("stored vector reported in span");

endmodule

// File: src/gf2_basis_span_tester.sv
// Reduced GF(2) basis with span test. Each request carries a command in
// s_tuser (clear, insert, query) and a vector in s_tdata; it walks a row of
// pivot cells from the top coordinate down, one cell per cycle that the
// result side accepts, and each cell holds one basis row. A new request
// enters every such cycle, so the sustained rate is one request per cycle; a
// request passes DIM cell registers and then the result register. Cells
// update as a request passes, so later requests always see the basis left by
// earlier ones. Reset empties the basis at once; no clearing pass is needed.
module gf2_basis_span_tester
    import gbst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // bit_vector[63:0]
    input  logic [1:0]  i_s_tuser,  // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata   // in_span[0], basis_rank[7:1]
);

    logic  w_adv;
    logic  w_valid [DIM:0];
    t_item w_item  [DIM:0];

    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    assign w_valid[DIM]       = i_s_tvalid;
    assign w_item[DIM].cmd    = i_s_tuser;
    assign w_item[DIM].vec    = i_s_tdata[DIM-1:0];
    assign w_item[DIM].done   = 1'b0;
    assign w_item[DIM].stored = 1'b0;

    for (genvar g = 0; g < DIM; g++) begin : g_cell
        gbst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_pos   (POS_W'(g)),
            .i_valid (w_valid[g+1]),
            .i_item  (w_item[g+1]),
            .o_valid (w_valid[g]),
            .o_item  (w_item[g])
        );
    end

    gbst_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (w_valid[0]),
        .i_item   (w_item[0]),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata)
    );

endmodule

// File: verif/gf2_basis_span_checker.sv
module gf2_basis_span_checker
    import gbst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,  // bit_vector[63:0]
    input  logic [1:0]  i_s_tuser,  // command[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,  // in_span[0], basis_rank[7:1]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic                  in_span;
        logic [RES_RANK_W-1:0] rank;
    } t_span_result;

    logic [DIM-1:0]        pivot_rows [DIM];
    logic [RES_RANK_W-1:0] rank_now;
    t_span_result          span_results_q [$];
    int                    fail_total = 0;

    function automatic void empty_basis();
        int k;
        for (k = 0; k < DIM; k++) begin
            pivot_rows[k] = '0;
        end
        rank_now = '0;
    endfunction

    function automatic t_span_result reduce_and_update(input logic [1:0] cmd,
                                                       input logic [63:0] raw);
        logic [DIM-1:0] v;
        int             piv;
        int             p;
        t_span_result   r;
        v         = raw[DIM-1:0];
        piv       = -1;
        r.in_span = 1'b0;
        if (cmd == CMD_CLEAR) begin
            empty_basis();
        end else if (cmd == CMD_INSERT || cmd == CMD_QUERY) begin
            // walk the pivots from the top, stop at the first empty one whose bit is set
            for (p = DIM - 1; p >= 0; p--) begin
                if (piv < 0 && v[p]) begin
                    if (pivot_rows[p] != '0) begin
                        v = v ^ pivot_rows[p];
                    end else begin
                        piv = p;
                    end
                end
            end
            if (piv < 0) begin
                r.in_span = 1'b1;
            end else if (cmd == CMD_INSERT) begin
                pivot_rows[piv] = v;
                if (rank_now < DIM) begin
                    rank_now = rank_now + 1'b1;
                end
            end
        end
        r.rank = rank_now;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_span_result want;
        if (!i_rst_n) begin
            empty_basis();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (span_results_q.size() == 0) begin
                    $display("%0t: unexpected result: actual in_span %0d rank %0d",
                             $time, i_m_tdata[0], i_m_tdata[7:1]);
                    fail_total++;
                end else begin
                    want = span_results_q.pop_front();
                    if (i_m_tdata[0] !== want.in_span) begin
                        $display("%0t: in_span mismatch: expected %0d, actual %0d",
                                 $time, want.in_span, i_m_tdata[0]);
                        fail_total++;
                    end
                    if (i_m_tdata[7:1] !== want.rank) begin
                        $display("%0t: basis_rank mismatch: expected %0d, actual %0d",
                                 $time, want.rank, i_m_tdata[7:1]);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                span_results_q = {span_results_q,
                                  reduce_and_update(i_s_tuser, i_s_tdata)};
            end
        end
        o_pending    <= span_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/tb_gf2_basis_span_tester.sv
module tb_gf2_basis_span_tester;
    import gbst_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         N_ITEMS        = 1100;
    localparam int         CALM_FROM      = 950;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // bit_vector[63:0]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // in_span[0], basis_rank[7:1]

    int          fail_count;
    int          exp_pending;
    int          items_sent = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    logic [63:0] members [$];

    gf2_basis_span_tester u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    gf2_basis_span_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (exp_pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] rand_vec();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [63:0] vec);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vec;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_CLEAR) begin
            members.delete();
        end else if (cmd == CMD_INSERT) begin
            members = {members, vec};
        end
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    // result side
    initial begin
        m_tready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (gaps_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [63:0] mask;
        logic [63:0] combo;
        int          mode;
        int          n_ins;
        int          n_q;
        int          k;
        int          q;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_CLEAR;
        rst_n    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        send_request(CMD_QUERY,  64'd0);
        send_request(CMD_QUERY,  '1);
        send_request(CMD_INSERT, 64'd0);
        send_request(CMD_INSERT, 64'h1);
        send_request(CMD_INSERT, 64'h8000_0000_0000_0000);
        send_request(CMD_QUERY,  64'h8000_0000_0000_0001);
        send_request(CMD_INSERT, 64'h8000_0000_0000_0001);
        send_request(CMD_QUERY,  64'h2);
        send_request(CMD_INSERT, '1);
        send_request(CMD_INSERT, '1);
        send_request(CMD_QUERY,  64'h7FFF_FFFF_FFFF_FFFE);
        send_request(CMD_UNUSED, '1);
        send_request(CMD_UNUSED, 64'd0);
        send_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(CMD_INSERT, 64'h5555_5555_5555_5555);
        send_request(CMD_QUERY,  '1);
        send_request(CMD_CLEAR,  '1);
        send_request(CMD_QUERY,  64'h1);
        send_request(CMD_CLEAR,  64'd0);
        send_request(CMD_INSERT, 64'h8000_0000_0000_0000);
        send_request(CMD_QUERY,  64'd0);
        send_request(CMD_QUERY,  64'h4000_0000_0000_0000);

        while (items_sent < N_ITEMS) begin
            if (!hold_done && items_sent > 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= CALM_FROM) begin
                gaps_on = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                // full rank, then dependent inserts and queries
                send_request(CMD_CLEAR, rand_vec());
                q = $urandom_range(0, 1);
                for (k = 0; k < DIM; k++) begin
                    n_ins = q ? (DIM - 1 - k) : k;
                    send_request(CMD_INSERT,
                                 (rand_vec() >> (DIM - 1 - n_ins)) | (64'd1 << n_ins));
                end
                repeat ($urandom_range(1, 4)) send_request(CMD_INSERT, rand_vec());
                repeat ($urandom_range(1, 4)) send_request(CMD_QUERY, rand_vec());
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    send_request(CMD_CLEAR, rand_vec());
                end
                if (mode <= 3) begin
                    mask = rand_vec() & rand_vec() & rand_vec();
                end else if (mode <= 6) begin
                    mask = '1;
                end else begin
                    mask = rand_vec();
                end
                n_ins = $urandom_range(1, 12);
                for (k = 0; k < n_ins; k++) begin
                    send_request(CMD_INSERT, rand_vec() & mask);
                end
                n_q = $urandom_range(1, 8);
                for (k = 0; k < n_q; k++) begin
                    combo = '0;
                    foreach (members[j]) begin
                        if ($urandom_range(0, 1)) combo ^= members[j];
                    end
                    case ($urandom_range(0, 3))
                        0: send_request(CMD_QUERY, combo);
                        1: send_request(CMD_QUERY, combo ^ (64'd1 << $urandom_range(0, 63)));
                        2: send_request(CMD_QUERY, rand_vec() & mask);
                        default: send_request(CMD_QUERY, rand_vec());
                    endcase
                end
                if ($urandom_range(0, 7) == 0) begin
                    send_request(2'($urandom_range(0, 3)), rand_vec());
                end
            end
        end

        s_tvalid <= 1'b0;
        while (exp_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && exp_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/gbst_pkg.sv
src/gbst_cell.sv
src/gbst_out.sv
src/gf2_basis_span_tester.sv
verif/gf2_basis_span_checker.sv
verif/tb_gf2_basis_span_tester.sv
